>>> rtl/nearest_neighbor_downscaler_defines.svh
// Assertion macros used by the downscaler RTL.
`ifndef NEAREST_NEIGHBOR_DOWNSCALER_DEFINES_SVH
`define NEAREST_NEIGHBOR_DOWNSCALER_DEFINES_SVH

// Condition and consequence checked in the same cycle.
`define NNDS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequence checked in the cycle after the condition.
`define NNDS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/nnds_pkg.sv
// Types, constants and helper functions of the nearest neighbor downscaler.
`default_nettype none
package nnds_pkg;

   // Largest frame dimension and the derived widths.
   localparam int MAX_DIMENSION = 4096;
   localparam int DIM_W         = 13;   // size registers, can hold MAX_DIMENSION
   localparam int COORD_W       = 12;   // source coordinates
   localparam int NUM_W         = 24;   // numerator accumulators
   localparam int BOUND_W       = 25;   // bound accumulators and bound plus size
   localparam int INDEX_W       = 24;   // output pixel index
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 13;
   localparam int REQ_DATA_W    = 24;
   localparam int RSP_DATA_W    = 72;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SOURCE_WIDTH       = 3'd0,
      REG_SOURCE_HEIGHT      = 3'd1,
      REG_TARGET_WIDTH       = 3'd2,
      REG_TARGET_HEIGHT      = 3'd3,
      REG_CHANNEL_COUNT      = 3'd4,
      REG_INTERLEAVED_LAYOUT = 3'd5
   } csr_index_type;

   // Reset values of the configuration registers.
   localparam logic [DIM_W-1:0] SOURCE_WIDTH_RESET  = 13'd640;
   localparam logic [DIM_W-1:0] SOURCE_HEIGHT_RESET = 13'd480;
   localparam logic [DIM_W-1:0] TARGET_WIDTH_RESET  = 13'd192;
   localparam logic [DIM_W-1:0] TARGET_HEIGHT_RESET = 13'd192;
   localparam logic [1:0]       CHANNEL_COUNT_RESET = 2'd3;
   localparam logic [1:0]       CHANNEL_COUNT_ALL   = 2'd3;
   localparam logic [DIM_W-1:0] DIM_LIMIT           = DIM_W'(MAX_DIMENSION);

   // Result payload, last field in the lowest bits.
   typedef struct packed {
      logic [7:0]         chan2;
      logic [7:0]         chan1;
      logic [7:0]         chan0;
      logic [INDEX_W-1:0] raster_index;
      logic [COORD_W-1:0] out_y;
      logic [COORD_W-1:0] out_x;
   } rsp_payload_type;

   // A size of zero acts as one, a size above the limit acts as the limit.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] value,
                                                  input logic [DIM_W-1:0] limit);
      logic [DIM_W-1:0] result;
      result = value;
      if (value == '0) begin
         result = DIM_W'(1);
      end else if (value > limit) begin
         result = limit;
      end
      return result;
   endfunction

endpackage
`default_nettype wire

>>> rtl/nearest_neighbor_downscaler.sv
// Streaming nearest neighbor downscaler: picks source pixels for a smaller output frame.
//
// Source BGR pixels enter in raster order, one transaction per pixel, and the block emits
// the pixels that nearest neighbor sampling keeps, with their output coordinates, running
// pixel index and channels in layout order; rsp_tlast marks the final output pixel of a
// frame. The block takes one source pixel every clock cycle as long as the output side
// keeps up: the row and column add-and-compare accumulators update in the cycle of the
// transaction and a kept pixel is registered for the result port. An output
// register backed by a one-entry skid buffer lets the input keep flowing while one result
// waits; req_tready drops only when both hold a result. The configuration port is always
// ready; any write to a listed register restarts the frame. Targets larger than the
// source are clamped, so each source pixel gives at most one output pixel.
`default_nettype none
`include "nearest_neighbor_downscaler_defines.svh"
module nearest_neighbor_downscaler (
   input  wire logic        clock,
   input  wire logic        reset,
   // Source pixel channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // blue[7:0], green[15:8], red[23:16]
   // Result channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // out_x[11:0], out_y[23:12], raster_index[47:24],
                                         // chan0[55:48], chan1[63:56], chan2[71:64]
   output logic             rsp_tlast,   // last_of_frame
   // Configuration write channel.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [12:0] csr_data
);

   localparam int DIM_W   = nnds_pkg::DIM_W;
   localparam int COORD_W = nnds_pkg::COORD_W;
   localparam int NUM_W   = nnds_pkg::NUM_W;
   localparam int BOUND_W = nnds_pkg::BOUND_W;
   localparam int INDEX_W = nnds_pkg::INDEX_W;

   // Configuration registers.
   logic [DIM_W-1:0] source_width_ff, source_height_ff;
   logic [DIM_W-1:0] target_width_ff, target_height_ff;
   logic [1:0]       channel_count_ff;
   logic             interleaved_ff;

   // Frame walk state; output counters can reach the target size itself.
   logic [COORD_W-1:0] src_col_ff,  src_col_in;
   logic [COORD_W-1:0] src_row_ff,  src_row_in;
   logic [DIM_W-1:0]   out_col_ff,  out_col_in;
   logic [DIM_W-1:0]   out_row_ff,  out_row_in;
   logic [NUM_W-1:0]   col_num_ff,  col_num_in;
   logic [BOUND_W-1:0] col_bound_ff, col_bound_in;
   logic [NUM_W-1:0]   row_num_ff,  row_num_in;
   logic [BOUND_W-1:0] row_bound_ff, row_bound_in;
   logic [INDEX_W-1:0] out_idx_ff,  out_idx_in;

   // Output register and skid buffer.
   nnds_pkg::rsp_payload_type rsp_data_ff, rsp_data_in, skid_data_ff, new_data;
   logic rsp_last_ff, rsp_last_in, skid_last_ff, new_last;
   logic rsp_valid_ff, rsp_valid_in, skid_valid_ff, skid_valid_in;

   logic [DIM_W-1:0] sw, sh, tw, th;
   logic [1:0]       cc;
   logic             csr_write, csr_restart, req_accept, rsp_pop;
   logic             row_hit, col_hit, hit, produce, col_wrap, row_wrap;
   logic [7:0]       pix_blue, pix_green, pix_red;

   assign csr_ready  = 1'b1;
   assign req_tready = !skid_valid_ff;
   assign csr_write  = csr_valid && csr_ready;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_pop    = rsp_valid_ff && rsp_tready;

   // Effective sizes after clamping.
   assign sw = nnds_pkg::clamp_dim(source_width_ff, nnds_pkg::DIM_LIMIT);
   assign sh = nnds_pkg::clamp_dim(source_height_ff, nnds_pkg::DIM_LIMIT);
   assign tw = nnds_pkg::clamp_dim(target_width_ff, sw);
   assign th = nnds_pkg::clamp_dim(target_height_ff, sh);
   assign cc = (channel_count_ff == 2'd0) ? nnds_pkg::CHANNEL_COUNT_ALL : channel_count_ff;

   // Keep test: next output coordinate times source size lies below the next bound.
   assign row_hit = ({1'b0, row_num_ff} < (row_bound_ff + BOUND_W'(th))) && (out_row_ff < th);
   assign col_hit = ({1'b0, col_num_ff} < (col_bound_ff + BOUND_W'(tw))) && (out_col_ff < tw);
   assign hit     = row_hit && col_hit;
   assign produce = req_accept && hit;

   assign col_wrap = ({1'b0, src_col_ff} + DIM_W'(1)) >= sw;
   assign row_wrap = ({1'b0, src_row_ff} + DIM_W'(1)) >= sh;

   assign pix_blue  = req_tdata[7:0];
   assign pix_green = req_tdata[15:8];
   assign pix_red   = req_tdata[23:16];

   // Result payload of the pixel in this transaction.
   always_comb begin
      new_data.out_x        = out_col_ff[COORD_W-1:0];
      new_data.out_y        = out_row_ff[COORD_W-1:0];
      new_data.raster_index = out_idx_ff;
      new_data.chan0        = interleaved_ff ? pix_red : pix_blue;
      new_data.chan1        = (cc >= 2'd2) ? pix_green : 8'd0;
      new_data.chan2        = (cc >= 2'd3) ? (interleaved_ff ? pix_blue : pix_red) : 8'd0;
      new_last = ((out_col_ff + DIM_W'(1)) == tw) && ((out_row_ff + DIM_W'(1)) == th);
   end

   // Frame walk: counters and accumulators advance by one source pixel.
   always_comb begin
      src_col_in   = src_col_ff;
      src_row_in   = src_row_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      col_num_in   = col_num_ff;
      col_bound_in = col_bound_ff;
      row_num_in   = row_num_ff;
      row_bound_in = row_bound_ff;
      out_idx_in   = out_idx_ff;
      if (req_accept) begin
         if (hit) begin
            out_idx_in = out_idx_ff + INDEX_W'(1);
            out_col_in = out_col_ff + DIM_W'(1);
            col_num_in = col_num_ff + NUM_W'(sw);
         end
         if (col_wrap) begin
            src_col_in   = '0;
            out_col_in   = '0;
            col_num_in   = '0;
            col_bound_in = '0;
            if (row_wrap) begin
               // End of frame: everything starts over.
               src_row_in   = '0;
               out_row_in   = '0;
               row_num_in   = '0;
               row_bound_in = '0;
               out_idx_in   = '0;
            end else begin
               if (row_hit) begin
                  out_row_in = out_row_ff + DIM_W'(1);
                  row_num_in = row_num_ff + NUM_W'(sh);
               end
               src_row_in   = src_row_ff + COORD_W'(1);
               row_bound_in = row_bound_ff + BOUND_W'(th);
            end
         end else begin
            src_col_in   = src_col_ff + COORD_W'(1);
            col_bound_in = col_bound_ff + BOUND_W'(tw);
         end
      end
   end

   // Output register fed from the skid buffer first, then from a new result.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      skid_valid_in = skid_valid_ff;
      if (!rsp_valid_ff || rsp_pop) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            rsp_last_in   = skid_last_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = produce;
            rsp_data_in  = new_data;
            rsp_last_in  = new_last;
         end
      end else if (produce) begin
         skid_valid_in = 1'b1;
      end
   end

   // A write to a listed register also restarts the frame.
   always_comb begin
      case (csr_index)
         nnds_pkg::REG_SOURCE_WIDTH,
         nnds_pkg::REG_SOURCE_HEIGHT,
         nnds_pkg::REG_TARGET_WIDTH,
         nnds_pkg::REG_TARGET_HEIGHT,
         nnds_pkg::REG_CHANNEL_COUNT,
         nnds_pkg::REG_INTERLEAVED_LAYOUT: csr_restart = csr_write;
         default:                          csr_restart = 1'b0;
      endcase
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         source_width_ff  <= nnds_pkg::SOURCE_WIDTH_RESET;
         source_height_ff <= nnds_pkg::SOURCE_HEIGHT_RESET;
         target_width_ff  <= nnds_pkg::TARGET_WIDTH_RESET;
         target_height_ff <= nnds_pkg::TARGET_HEIGHT_RESET;
         channel_count_ff <= nnds_pkg::CHANNEL_COUNT_RESET;
         interleaved_ff   <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            nnds_pkg::REG_SOURCE_WIDTH:       source_width_ff  <= csr_data;
            nnds_pkg::REG_SOURCE_HEIGHT:      source_height_ff <= csr_data;
            nnds_pkg::REG_TARGET_WIDTH:       target_width_ff  <= csr_data;
            nnds_pkg::REG_TARGET_HEIGHT:      target_height_ff <= csr_data;
            nnds_pkg::REG_CHANNEL_COUNT:      channel_count_ff <= csr_data[1:0];
            nnds_pkg::REG_INTERLEAVED_LAYOUT: interleaved_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Frame walk state.
   always_ff @(posedge clock) begin
      if (reset || csr_restart) begin
         src_col_ff   <= '0;
         src_row_ff   <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         col_num_ff   <= '0;
         col_bound_ff <= '0;
         row_num_ff   <= '0;
         row_bound_ff <= '0;
         out_idx_ff   <= '0;
      end else begin
         src_col_ff   <= src_col_in;
         src_row_ff   <= src_row_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         col_num_ff   <= col_num_in;
         col_bound_ff <= col_bound_in;
         row_num_ff   <= row_num_in;
         row_bound_ff <= row_bound_in;
         out_idx_ff   <= out_idx_in;
      end
   end

   // Output valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Output and skid payloads.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (rsp_valid_ff && !rsp_pop && produce) begin
         skid_data_ff <= new_data;
         skid_last_ff <= new_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // The skid buffer only fills behind a stalled output register.
   `NNDS_ASSERT_NOW(a_skid_behind_output, skid_valid_ff, rsp_valid_ff,
                    "skid buffer holds a result while the output register is empty")
   // The output column and row never run past the effective target width and height.
   `NNDS_ASSERT_NOW(a_out_col_bounded, 1'b1, (out_col_ff <= tw) && (out_row_ff <= th),
                    "output coordinate beyond the target size")
   // A kept pixel behind a stalled result must land in the skid buffer.
   `NNDS_ASSERT_NEXT(a_stall_fills_skid, rsp_valid_ff && !rsp_tready && produce,
                     skid_valid_ff, "result lost while the output was stalled")
   // A listed register write restarts the frame walk.
   `NNDS_ASSERT_NEXT(a_csr_restarts, csr_valid && csr_ready &&
                     (csr_index <= nnds_pkg::REG_INTERLEAVED_LAYOUT),
                     (src_col_ff == '0) && (src_row_ff == '0) && (out_idx_ff == '0),
                     "configuration write did not restart the frame")

endmodule
`default_nettype wire

>>> tb/nearest_neighbor_downscaler_tb.sv
// Self-checking testbench for the streaming nearest neighbor downscaler.
module nearest_neighbor_downscaler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import nnds_pkg::*;

   // Run control.
   localparam int MAX_REPORTS   = 10;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 20;
   localparam int TIMEOUT_NS    = 5_000_000;

   // Register indexes outside the defined register map.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   // One kept output pixel as the result port carries it.
   typedef struct packed {
      logic            frame_end;
      rsp_payload_type payload;
   } kept_pixel_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // Mirror of the configuration registers.
   logic [DIM_W-1:0] cfg_src_w, cfg_src_h, cfg_tgt_w, cfg_tgt_h;
   logic [1:0]       cfg_chan_cnt;
   logic             cfg_interleaved;

   // Mirror of the frame position and the sampling accumulators.
   logic [DIM_W-1:0]   src_col, src_row, out_col, out_row;
   logic [25:0]        col_num, col_bound, row_num, row_bound;
   logic [INDEX_W-1:0] out_index;

   kept_pixel_type awaited_pixels[$];
   int             failures = 0;
   int             pixels_sent = 0;
   bit             steady = 1'b0;

   nearest_neighbor_downscaler i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Clock generation.
   initial begin
      forever #5 clock = ~clock;
   end

   // Size register as the block uses it: zero acts as one, anything above the limit as the limit.
   function automatic logic [DIM_W-1:0] bounded_size(input logic [DIM_W-1:0] value,
                                                     input logic [DIM_W-1:0] limit);
      if (value == '0) begin
         return DIM_W'(1);
      end
      if (value > limit) begin
         return limit;
      end
      return value;
   endfunction

   // Return the frame position and accumulators to the top left corner.
   task automatic restart_frame();
      src_col   = '0;
      src_row   = '0;
      out_col   = '0;
      out_row   = '0;
      col_num   = '0;
      col_bound = '0;
      row_num   = '0;
      row_bound = '0;
      out_index = '0;
   endtask

   // Register write as the block sees it; any listed register restarts the frame.
   task automatic record_register(input logic [CSR_INDEX_W-1:0] idx,
                                  input logic [CSR_DATA_W-1:0] value);
      case (idx)
         REG_SOURCE_WIDTH: begin
            cfg_src_w = value;
         end
         REG_SOURCE_HEIGHT: begin
            cfg_src_h = value;
         end
         REG_TARGET_WIDTH: begin
            cfg_tgt_w = value;
         end
         REG_TARGET_HEIGHT: begin
            cfg_tgt_h = value;
         end
         REG_CHANNEL_COUNT: begin
            cfg_chan_cnt = value[1:0];
         end
         REG_INTERLEAVED_LAYOUT: begin
            cfg_interleaved = value[0];
         end
         default: begin
            return;
         end
      endcase
      restart_frame();
   endtask

   // Decide whether one source pixel is kept, queue the output pixel it makes
   // and advance the raster position.
   task automatic select_source_pixel(input logic [REQ_DATA_W-1:0] px);
      logic [DIM_W-1:0] sw, sh, tw, th;
      logic [1:0]       cc;
      logic [7:0]       blue, green, red;
      logic             row_hit, col_hit;
      kept_pixel_type   kept;
      sw    = bounded_size(cfg_src_w, DIM_LIMIT);
      sh    = bounded_size(cfg_src_h, DIM_LIMIT);
      tw    = bounded_size(cfg_tgt_w, sw);
      th    = bounded_size(cfg_tgt_h, sh);
      cc    = (cfg_chan_cnt == 2'd0) ? CHANNEL_COUNT_ALL : cfg_chan_cnt;
      blue  = px[7:0];
      green = px[15:8];
      red   = px[23:16];
      row_hit = (row_num < row_bound + 26'(th)) && (out_row < th);
      col_hit = (col_num < col_bound + 26'(tw)) && (out_col < tw);

      if (row_hit && col_hit) begin
         kept.payload.out_x        = out_col[COORD_W-1:0];
         kept.payload.out_y        = out_row[COORD_W-1:0];
         kept.payload.raster_index = out_index;
         kept.payload.chan0        = cfg_interleaved ? red : blue;
         kept.payload.chan1        = (cc >= 2'd2) ? green : 8'd0;
         kept.payload.chan2        = (cc >= 2'd3) ? (cfg_interleaved ? blue : red) : 8'd0;
         kept.frame_end            = (out_col + 13'd1 == tw) && (out_row + 13'd1 == th);
         awaited_pixels.push_back(kept);
         out_index = out_index + 1'b1;
         out_col   = out_col + 1'b1;
         col_num   = col_num + 26'(sw);
      end

      // Advance along the row, then to the next row, then to the next frame.
      if (src_col + 13'd1 >= sw) begin
         if (src_row + 13'd1 >= sh) begin
            restart_frame();
         end else begin
            src_col   = '0;
            out_col   = '0;
            col_num   = '0;
            col_bound = '0;
            if (row_hit) begin
               out_row = out_row + 1'b1;
               row_num = row_num + 26'(sh);
            end
            src_row   = src_row + 1'b1;
            row_bound = row_bound + 26'(th);
         end
      end else begin
         src_col   = src_col + 1'b1;
         col_bound = col_bound + 26'(tw);
      end
   endtask

   // Send one source pixel; optionally hold off until every awaited pixel has arrived.
   task automatic push_pixel(input logic [REQ_DATA_W-1:0] px, input bit hold);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 10);
      if (hold || gap > 0) begin
         req_tvalid <= 1'b0;
         if (hold) begin
            do @(posedge clock); while (awaited_pixels.size() != 0);
         end
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      do @(posedge clock); while (!req_tready);
      select_source_pixel(px);
      pixels_sent++;
   endtask

   // Stop sending and let the block empty out before a register write.
   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (awaited_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One configuration transaction.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      record_register(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Bring the block to idle and write the whole register set.
   task automatic apply_geometry(input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh,
                                 input logic [DIM_W-1:0] tw, input logic [DIM_W-1:0] th,
                                 input logic [CSR_DATA_W-1:0] cc,
                                 input logic [CSR_DATA_W-1:0] layout);
      quiesce();
      write_register(REG_SOURCE_WIDTH, sw);
      write_register(REG_SOURCE_HEIGHT, sh);
      write_register(REG_TARGET_WIDTH, tw);
      write_register(REG_TARGET_HEIGHT, th);
      write_register(REG_CHANNEL_COUNT, cc);
      write_register(REG_INTERLEAVED_LAYOUT, layout);
   endtask

   // Reset geometry: 640x480 source down to 192x192, planar, three channels.
   task automatic test_reset_geometry();
      push_pixel(24'h000000, 1'b0);
      push_pixel(24'hFFFFFF, 1'b0);
      push_pixel(24'h5AA55A, 1'b0);
      push_pixel(24'hA55AA5, 1'b0);
   endtask

   // Zero sizes act as one and a target above the source is clamped to it.
   task automatic test_degenerate_sizes();
      int i;
      apply_geometry(13'd0, 13'd0, 13'd0, 13'd0, 13'd3, 13'd0);
      push_pixel(24'h123456, 1'b0);
      push_pixel(24'hEDCBA9, 1'b0);
      apply_geometry(13'd3, 13'd2, 13'h1FFF, 13'd7, 13'd3, 13'd1);
      for (i = 0; i < 6; i++) begin
         push_pixel(REQ_DATA_W'($urandom()), 1'b0);
      end
   endtask

   // Sizes above the limit act as the limit.
   task automatic test_oversize_dimensions();
      int i;
      apply_geometry(13'h1FFF, 13'd4096, 13'd4096, 13'h1FFF, 13'd2, 13'd0);
      for (i = 0; i < 4; i++) begin
         push_pixel(REQ_DATA_W'($urandom()), 1'b0);
      end
   endtask

   // Channel count and layout, with unused high data bits set on some writes.
   task automatic test_channel_layouts();
      apply_geometry(13'd2, 13'd1, 13'd2, 13'd1, 13'h1FFC, 13'h1FFF);
      push_pixel(24'hC35A96, 1'b0);
      apply_geometry(13'd2, 13'd1, 13'd2, 13'd1, 13'h0001, 13'h1FFE);
      push_pixel(24'hC35A96, 1'b0);
      apply_geometry(13'd2, 13'd1, 13'd2, 13'd1, 13'h0AA2, 13'd1);
      push_pixel(24'h3CA569, 1'b0);
      apply_geometry(13'd2, 13'd1, 13'd2, 13'd1, 13'd3, 13'd1);
      push_pixel(24'h3CA569, 1'b0);
   endtask

   // A listed register write restarts the frame; a write to an unlisted index does not.
   task automatic test_frame_restart();
      apply_geometry(13'd4, 13'd2, 13'd2, 13'd1, 13'd3, 13'd0);
      push_pixel(24'h010203, 1'b0);
      push_pixel(24'h040506, 1'b0);
      push_pixel(24'h070809, 1'b0);
      quiesce();
      write_register(REG_INTERLEAVED_LAYOUT, 13'd0);
      push_pixel(24'h0A0B0C, 1'b0);
      quiesce();
      write_register(CSR_SPARE_LO, 13'h1FFF);
      write_register(CSR_SPARE_HI, 13'h0AAA);
      push_pixel(24'h0D0E0F, 1'b0);
      push_pixel(24'h101112, 1'b0);
   endtask

   // A few pixels at the largest sizes; the frames are cut short by the next write.
   task automatic test_large_frames();
      int i;
      apply_geometry(13'd4096, 13'd4096, 13'd4096, 13'd4096, 13'd3, 13'd1);
      for (i = 0; i < 24; i++) begin
         push_pixel(REQ_DATA_W'($urandom()), 1'b0);
      end
      apply_geometry(13'd1, 13'h1FFF, 13'd1, 13'd4096, 13'd3, 13'd0);
      for (i = 0; i < 20; i++) begin
         push_pixel(REQ_DATA_W'($urandom()), 1'b0);
      end
      apply_geometry(13'd4096, 13'd2, 13'd1, 13'd1, 13'd1, 13'd1);
      for (i = 0; i < 12; i++) begin
         push_pixel(REQ_DATA_W'($urandom()), 1'b0);
      end
   endtask

   // Random geometries, mostly whole frames with random content and some cut-off frames.
   task automatic test_random_frames(input int budget);
      int               start_count, frame_px, count, i;
      logic [DIM_W-1:0] sw, sh, tw, th, sw_eff, sh_eff;
      logic [CSR_DATA_W-1:0] cc_data, layout_data;
      start_count = pixels_sent;
      while (pixels_sent - start_count < budget) begin
         case ($urandom_range(0, 9))
            0: sw = '0;
            1: sw = DIM_W'($urandom_range(13, 40));
            default: sw = DIM_W'($urandom_range(1, 12));
         endcase
         sh = ($urandom_range(0, 9) == 0) ? '0 : DIM_W'($urandom_range(1, 8));
         sw_eff = bounded_size(sw, DIM_LIMIT);
         sh_eff = bounded_size(sh, DIM_LIMIT);
         tw = ($urandom_range(0, 9) == 0) ? 13'h1FFF : DIM_W'($urandom_range(0, sw_eff + 2));
         th = ($urandom_range(0, 9) == 0) ? 13'h1FFF : DIM_W'($urandom_range(0, sh_eff + 2));
         if ($urandom_range(0, 3) == 0) begin
            cc_data     = CSR_DATA_W'($urandom());
            layout_data = CSR_DATA_W'($urandom());
         end else begin
            cc_data     = CSR_DATA_W'($urandom_range(0, 3));
            layout_data = CSR_DATA_W'($urandom_range(0, 1));
         end
         apply_geometry(sw, sh, tw, th, cc_data, layout_data);
         steady   = ($urandom_range(0, 4) == 0);
         frame_px = int'(sw_eff) * int'(sh_eff);
         if ($urandom_range(0, 4) == 0) begin
            count = $urandom_range(1, frame_px);
         end else begin
            count = frame_px * ((frame_px > 60) ? 1 : $urandom_range(1, 3));
         end
         // Stay within the pixel budget of the whole run.
         if (count > budget - (pixels_sent - start_count)) begin
            count = budget - (pixels_sent - start_count);
         end
         for (i = 0; i < count; i++) begin
            push_pixel(REQ_DATA_W'($urandom()), $urandom_range(0, 24) == 0);
         end
         steady = 1'b0;
      end
   endtask

   // Result side: random stalls, then each accepted transaction is checked in order.
   initial begin
      int              stall;
      kept_pixel_type  want;
      rsp_payload_type got;
      wait (reset == 1'b0);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got = rsp_tdata;
         if (awaited_pixels.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
               $display("Unexpected result: x=%0d y=%0d index=%0d chan=%02h/%02h/%02h last=%0b",
                        got.out_x, got.out_y, got.raster_index, got.chan0, got.chan1,
                        got.chan2, rsp_tlast);
            end
         end else begin
            want = awaited_pixels.pop_front();
            if (got.out_x !== want.payload.out_x || got.out_y !== want.payload.out_y ||
                got.raster_index !== want.payload.raster_index ||
                got.chan0 !== want.payload.chan0 || got.chan1 !== want.payload.chan1 ||
                got.chan2 !== want.payload.chan2 || rsp_tlast !== want.frame_end) begin
               failures++;
               if (failures <= MAX_REPORTS) begin
                  $display("Mismatch: expected x=%0d y=%0d index=%0d chan=%02h/%02h/%02h last=%0b",
                           want.payload.out_x, want.payload.out_y, want.payload.raster_index,
                           want.payload.chan0, want.payload.chan1, want.payload.chan2,
                           want.frame_end);
                  $display("          actual   x=%0d y=%0d index=%0d chan=%02h/%02h/%02h last=%0b",
                           got.out_x, got.out_y, got.raster_index, got.chan0, got.chan1,
                           got.chan2, rsp_tlast);
               end
            end
         end
      end
   end

   // Watchdog against a hung handshake.
   initial begin
      #(TIMEOUT_NS);
      $display("Regression FAIL");
      $finish;
   end

   // Test sequence.
   initial begin
      cfg_src_w       = SOURCE_WIDTH_RESET;
      cfg_src_h       = SOURCE_HEIGHT_RESET;
      cfg_tgt_w       = TARGET_WIDTH_RESET;
      cfg_tgt_h       = TARGET_HEIGHT_RESET;
      cfg_chan_cnt    = CHANNEL_COUNT_RESET;
      cfg_interleaved = 1'b0;
      restart_frame();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_geometry();
      test_degenerate_sizes();
      test_oversize_dimensions();
      test_channel_layouts();
      test_frame_restart();
      test_large_frames();
      test_random_frames(820);

      quiesce();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && awaited_pixels.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
